// ===== hw/rtl/wrrq_pkg.sv =====
// Shared types, widths and codes of the weighted round-robin run queue.
// Used by wrrq_exec and weighted_round_robin_runqueue_core; no dependencies.
package wrrq_pkg;

  localparam int MAX_TASKS   = 64;
  localparam int TASK_W      = $clog2(MAX_TASKS);
  localparam int WEIGHT_W    = 5;
  localparam int MAX_WEIGHT  = 20;
  localparam int SLICE_W     = 8;
  localparam int TOTAL_W     = 11;
  localparam int COUNT_W     = 7;
  localparam int RATE_W      = 10;
  localparam int MODE_W      = 3;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^15
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_100   = 41944;
  localparam int SCALE_W     = 26;
  localparam int RATE_RESET  = 100;
  localparam int PROD_W      = WEIGHT_W + SCALE_W;
  localparam int QUO_W       = PROD_W - RECIP_SHIFT;

  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 40;

  typedef logic [TASK_W-1:0]   task_id_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [SLICE_W-1:0]  slice_t;
  typedef logic [TOTAL_W-1:0]  total_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [SCALE_W-1:0]  scale_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQUEUE = 3'd0,
    MODE_DEQUEUE = 3'd1,
    MODE_YIELD   = 3'd2,
    MODE_TICK    = 3'd3,
    MODE_SET_WT  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_WEIGHT = 2'd1,
    STAT_NOT_QUEUED = 2'd2,
    STAT_DUPLICATE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    task_id_t          tid;
    weight_t           weight;
  } item_t;

  // queue bookkeeping kept in flops
  typedef struct packed {
    task_id_t head;
    task_id_t tail;
    count_t   count;
    total_t   total;
  } rq_state_t;

  // registered store reads for the item in execute
  typedef struct packed {
    weight_t  w_tid;
    weight_t  w_head;
    slice_t   s_tid;
    slice_t   s_head;
    task_id_t n_tid;
    task_id_t n_head;
    task_id_t p_tid;
  } rd_data_t;

  // store and flag writes produced by one operation
  typedef struct packed {
    logic     w_we;
    task_id_t w_addr;
    weight_t  w_data;
    logic     s_we;
    task_id_t s_addr;
    slice_t   s_data;
    logic     n_we;
    task_id_t n_addr;
    task_id_t n_data;
    logic     p_we;
    task_id_t p_addr;
    task_id_t p_data;
    logic     f_we;
    task_id_t f_addr;
    logic     f_data;
  } wr_req_t;

  // result beat, last field in the lowest bits
  typedef struct packed {
    slice_t   task_slice;
    count_t   queued_count;
    total_t   total_weight;
    logic     need_resched;
    task_id_t head_task;
    logic     head_valid;
    status_t  status;
  } result_t;

endpackage

// ===== hw/rtl/weighted_round_robin_runqueue_core.sv =====
// Top level of the weighted round-robin run queue: stores, execute stage, result register.
// Depends on wrrq_pkg and wrrq_exec.
//
// Usage
// - in_*: one operation per beat. in_tuser carries the mode (enqueue, dequeue,
//   yield, tick, set weight); in_tdata carries task_id and weight.
// - out_*: one result beat per operation, in order: status, head, need_resched,
//   weight sum, queued count and the slice of the named task.
// - cfg_*: tick_rate writes; cfg_ready is always high. Write only while idle.
// Timing
// - An accepted beat sits in the execute register; its result is loaded into
//   the output register once that register is free or being emptied, and
//   out_tvalid then rises.
// - One beat per cycle sustained while out_tready is high. Each operation is
//   a fixed set of link and store updates; store reads for the next beat are
//   taken at the same edge, addressed by its task id and by the head the
//   current operation leaves, with write data bypassed on an address match.
// Reset and stall
// - rst_n (synchronous) empties the queue and sets tick_rate to 100; the task
//   stores are not cleared.
// - When out_tready is low with a result waiting, the result holds, the execute
//   stage holds any beat it has, and in_tready drops until the result is taken.
module weighted_round_robin_runqueue_core
  import wrrq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // operation channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [5:0] task_id, [10:6] weight, rest zero
  input  logic [MODE_W-1:0]     in_tuser,   // [2:0] mode
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [1:0] status, [2] head_valid,
                                            // [8:3] head_task, [9] need_resched,
                                            // [20:10] total_weight,
                                            // [27:21] queued_count,
                                            // [35:28] task_slice, rest zero
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RATE_W-1:0]     cfg_data    // tick_rate
);

  // per-task stores
  weight_t  weight_mem [MAX_TASKS];
  slice_t   slice_mem  [MAX_TASKS];
  task_id_t next_mem   [MAX_TASKS];
  task_id_t prev_mem   [MAX_TASKS];

  logic [MAX_TASKS-1:0] queued_r, queued_nxt;
  rq_state_t st_r, st_nxt, exec_st;
  scale_t    scale_r;
  logic      e_valid_r;
  item_t     item_r;
  rd_data_t  rd_r;
  logic      out_valid_r;
  result_t   out_data_r, exec_res;
  wr_req_t   exec_wr;

  logic      commit;
  logic      in_fire;
  task_id_t  in_tid;
  weight_t   in_weight;
  task_id_t  head_addr;

  // bypass hits for the reads taken with the incoming beat
  logic hit_w_tid, hit_w_head, hit_s_tid, hit_s_head;
  logic hit_n_tid, hit_n_head, hit_p_tid;

  assign in_tid    = in_tdata[TASK_W-1:0];
  assign in_weight = in_tdata[TASK_W +: WEIGHT_W];

  // execute retires when the output register is free or being emptied
  assign commit    = e_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !e_valid_r || commit;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  wrrq_exec u_exec (
    .item   (item_r),
    .rd     (rd_r),
    .st     (st_r),
    .q_tid  (queued_r[item_r.tid]),
    .scale  (scale_r),
    .st_nxt (exec_st),
    .wr     (exec_wr),
    .res    (exec_res)
  );

  always_comb begin
    st_nxt     = commit ? exec_st : st_r;
    head_addr  = st_nxt.head;
    queued_nxt = queued_r;
    if (commit && exec_wr.f_we) begin
      queued_nxt[exec_wr.f_addr] = exec_wr.f_data;
    end
  end

  always_comb begin
    hit_w_tid  = commit && exec_wr.w_we && (exec_wr.w_addr == in_tid);
    hit_w_head = commit && exec_wr.w_we && (exec_wr.w_addr == head_addr);
    hit_s_tid  = commit && exec_wr.s_we && (exec_wr.s_addr == in_tid);
    hit_s_head = commit && exec_wr.s_we && (exec_wr.s_addr == head_addr);
    hit_n_tid  = commit && exec_wr.n_we && (exec_wr.n_addr == in_tid);
    hit_n_head = commit && exec_wr.n_we && (exec_wr.n_addr == head_addr);
    hit_p_tid  = commit && exec_wr.p_we && (exec_wr.p_addr == in_tid);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      queued_r    <= '0;
      scale_r     <= SCALE_W'(RATE_RESET * RECIP_100);
    end else begin
      if (cfg_valid) begin
        scale_r <= SCALE_W'(cfg_data) * SCALE_W'(RECIP_100);
      end
      if (in_fire) begin
        e_valid_r <= 1'b1;
      end else if (commit) begin
        e_valid_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      st_r     <= st_nxt;
      queued_r <= queued_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.mode   <= in_tuser;
      item_r.tid    <= in_tid;
      item_r.weight <= in_weight;
    end
    if (commit) begin
      out_data_r <= exec_res;
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (commit && exec_wr.w_we) begin
      weight_mem[exec_wr.w_addr] <= exec_wr.w_data;
    end
    if (commit && exec_wr.s_we) begin
      slice_mem[exec_wr.s_addr] <= exec_wr.s_data;
    end
    if (commit && exec_wr.n_we) begin
      next_mem[exec_wr.n_addr] <= exec_wr.n_data;
    end
    if (commit && exec_wr.p_we) begin
      prev_mem[exec_wr.p_addr] <= exec_wr.p_data;
    end
  end

  // registered store reads for the beat entering execute
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_r.w_tid  <= hit_w_tid  ? exec_wr.w_data : weight_mem[in_tid];
      rd_r.w_head <= hit_w_head ? exec_wr.w_data : weight_mem[head_addr];
      rd_r.s_tid  <= hit_s_tid  ? exec_wr.s_data : slice_mem[in_tid];
      rd_r.s_head <= hit_s_head ? exec_wr.s_data : slice_mem[head_addr];
      rd_r.n_tid  <= hit_n_tid  ? exec_wr.n_data : next_mem[in_tid];
      rd_r.n_head <= hit_n_head ? exec_wr.n_data : next_mem[head_addr];
      rd_r.p_tid  <= hit_p_tid  ? exec_wr.p_data : prev_mem[in_tid];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), out_data_r};

endmodule

// ===== hw/rtl/wrrq_exec.sv =====
// One run-queue operation as combinational logic: state, store reads -> writes, result.
// Depends on wrrq_pkg.
module wrrq_exec
  import wrrq_pkg::*;
(
  input  item_t     item,
  input  rd_data_t  rd,
  input  rq_state_t st,
  input  logic      q_tid,    // queued flag of item.tid
  input  scale_t    scale,    // tick_rate * RECIP_100
  output rq_state_t st_nxt,
  output wr_req_t   wr,
  output result_t   res
);

  logic               wvalid;
  weight_t            fs_w;
  logic [PROD_W-1:0]  prod;
  logic [QUO_W-1:0]   quo;
  slice_t             full;
  status_t            status;
  logic               resched;

  // full slice = weight * tick_rate / 100, saturated
  always_comb begin
    fs_w = (mode_t'(item.mode) == MODE_TICK) ? rd.w_head : item.weight;
    prod = PROD_W'(fs_w) * PROD_W'(scale);
    quo  = prod[PROD_W-1:RECIP_SHIFT];
    full = (quo > QUO_W'(2**SLICE_W - 1)) ? '1 : quo[SLICE_W-1:0];
  end

  assign wvalid = (item.weight != '0) && (item.weight <= WEIGHT_W'(MAX_WEIGHT));

  always_comb begin
    st_nxt  = st;
    wr      = '0;
    status  = STAT_OK;
    resched = 1'b0;
    case (mode_t'(item.mode))
      MODE_ENQUEUE: begin
        if (!wvalid) begin
          status = STAT_BAD_WEIGHT;
        end else if (q_tid) begin
          status = STAT_DUPLICATE;
        end else begin
          wr.w_we   = 1'b1;
          wr.w_addr = item.tid;
          wr.w_data = item.weight;
          wr.s_we   = 1'b1;
          wr.s_addr = item.tid;
          wr.s_data = full;
          if (st.count == '0) begin
            st_nxt.head = item.tid;
          end else begin
            wr.n_we   = 1'b1;
            wr.n_addr = st.tail;
            wr.n_data = item.tid;
            wr.p_we   = 1'b1;
            wr.p_addr = item.tid;
            wr.p_data = st.tail;
          end
          st_nxt.tail  = item.tid;
          wr.f_we      = 1'b1;
          wr.f_addr    = item.tid;
          wr.f_data    = 1'b1;
          st_nxt.count = st.count + 1'b1;
          st_nxt.total = st.total + TOTAL_W'(item.weight);
        end
      end
      MODE_DEQUEUE: begin
        if (!q_tid) begin
          status = STAT_NOT_QUEUED;
        end else begin
          st_nxt.total = st.total - TOTAL_W'(rd.w_tid);
          if (item.tid == st.head) begin
            st_nxt.head = rd.n_tid;
          end else begin
            wr.n_we   = 1'b1;
            wr.n_addr = rd.p_tid;
            wr.n_data = rd.n_tid;
          end
          if (item.tid == st.tail) begin
            st_nxt.tail = rd.p_tid;
          end else begin
            wr.p_we   = 1'b1;
            wr.p_addr = rd.n_tid;
            wr.p_data = rd.p_tid;
          end
          wr.f_we      = 1'b1;
          wr.f_addr    = item.tid;
          wr.f_data    = 1'b0;
          st_nxt.count = st.count - 1'b1;
          if (st.count == COUNT_W'(1)) begin
            st_nxt.head = '0;
            st_nxt.tail = '0;
          end
        end
      end
      MODE_YIELD: begin
        if (st.count > COUNT_W'(1)) begin
          // head moves to the tail; prev of the new head is never read
          st_nxt.head = rd.n_head;
          st_nxt.tail = st.head;
          wr.n_we     = 1'b1;
          wr.n_addr   = st.tail;
          wr.n_data   = st.head;
          wr.p_we     = 1'b1;
          wr.p_addr   = st.head;
          wr.p_data   = st.tail;
        end
      end
      MODE_TICK: begin
        if (st.count != '0) begin
          wr.s_we   = 1'b1;
          wr.s_addr = st.head;
          if (rd.s_head > SLICE_W'(1)) begin
            wr.s_data = rd.s_head - 1'b1;
          end else begin
            wr.s_data = full;
            if (st.count > COUNT_W'(1)) begin
              resched     = 1'b1;
              st_nxt.head = rd.n_head;
              st_nxt.tail = st.head;
              wr.n_we     = 1'b1;
              wr.n_addr   = st.tail;
              wr.n_data   = st.head;
              wr.p_we     = 1'b1;
              wr.p_addr   = st.head;
              wr.p_data   = st.tail;
            end
          end
        end
      end
      MODE_SET_WT: begin
        if (!wvalid) begin
          status = STAT_BAD_WEIGHT;
        end else begin
          if (q_tid) begin
            st_nxt.total = st.total - TOTAL_W'(rd.w_tid) + TOTAL_W'(item.weight);
          end
          wr.w_we   = 1'b1;
          wr.w_addr = item.tid;
          wr.w_data = item.weight;
          // the running head keeps its slice
          if (!(q_tid && (item.tid == st.head))) begin
            wr.s_we   = 1'b1;
            wr.s_addr = item.tid;
            wr.s_data = full;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.status       = status;
    res.head_valid   = (st_nxt.count != '0);
    res.head_task    = (st_nxt.count != '0) ? st_nxt.head : '0;
    res.need_resched = resched;
    res.total_weight = st_nxt.total;
    res.queued_count = st_nxt.count;
    res.task_slice   = (wr.s_we && (wr.s_addr == item.tid)) ? wr.s_data : rd.s_tid;
  end

endmodule
